FILE: rtl/core/bbt_pkg.sv
// Shared constants, types and elaboration-time helpers for the blackbody color block.
// Used by every module under rtl/core; depends on nothing.
package bbt_pkg;

   // Output color depth and full-scale level.
   localparam int COLOR_BITS = 8;
   localparam logic [COLOR_BITS-1:0] LEVEL_MAX = '1;

   // Stream widths: tdata padded to whole bytes.
   localparam int KELVIN_W = 16;
   localparam int REQ_W    = ((KELVIN_W + 7) / 8) * 8;
   localparam int RSP_W    = ((3 * COLOR_BITS + 7) / 8) * 8;

   // Temperature limits and branch points, in kelvin.
   localparam logic [KELVIN_W-1:0] K_MIN      = 16'd500;
   localparam logic [KELVIN_W-1:0] K_MAX      = 16'd40000;
   localparam logic [KELVIN_W-1:0] K_KNEE     = 16'd6600;
   localparam logic [KELVIN_W-1:0] K_BLUE_OFF = 16'd1900;
   localparam logic [KELVIN_W-1:0] K_POW_OFS  = 16'd6000;
   localparam logic [KELVIN_W-1:0] K_BLUE_OFS = 16'd1000;

   // Datapath widths.
   localparam int LN_W   = 32;
   localparam int COEF_W = 40;
   localparam int POWP_W = 28;
   localparam int VAL_W  = 48;
   localparam int W_BITS = 29;
   localparam int LVL_XW = 40 + COLOR_BITS;
   localparam int LVL_RW = COLOR_BITS + 4;

   // Arithmetic constants (curve values are scaled by 1e9).
   localparam logic [31:0]       LN2_Q32 = 32'd2977044472;
   localparam logic [29:0]       DIV_E9  = 30'd1000000000;
   localparam logic [31:0]       DIV_2E9 = 32'd2000000000;
   localparam logic [39:0]       FULL_U  = 40'd255000000000;
   localparam logic [39:0]       FULL2_U = 40'd510000000000;
   localparam logic [39:0]       HALF_U  = 40'd127500000000;
   localparam logic signed [VAL_W-1:0] FULL_S = 48'sd255000000000;

   // Floor reciprocals used for the estimated quotients.
   localparam logic [W_BITS-1:0] W_RECIP   = W_BITS'((64'd1 << 58) / 64'd1000000000);
   localparam logic [LVL_RW-1:0] LVL_RECIP = LVL_RW'((64'd1 << LVL_XW) / {24'd0, FULL_U});

   // Curve coefficients.
   localparam logic [COEF_W-1:0] RED_C = 40'd329698727446;
   localparam logic [POWP_W-1:0] RED_P = 28'd133204759;
   localparam logic [COEF_W-1:0] GRN_A = 40'd99470802586;
   localparam logic [COEF_W-1:0] GRN_B = 40'd161119568166;
   localparam logic [COEF_W-1:0] GRN_C = 40'd288122169528;
   localparam logic [POWP_W-1:0] GRN_P = 28'd75514849;
   localparam logic [COEF_W-1:0] BLU_A = 40'd138517731223;
   localparam logic [COEF_W-1:0] BLU_B = 40'd305044792731;

   // Bit-serial log2 in Q28, evaluated only for constants at elaboration.
   function automatic logic [63:0] log2_q28_f(input logic [31:0] n);
      logic [63:0] m;
      logic [63:0] res;
      int          e;
      e = 0;
      for (int b = 0; b < 32; b++) begin
         if ((n >> b) != 32'd0) e = b;
      end
      m   = ({32'd0, n} << 28) >> e;
      res = 64'(e) << 28;
      for (int i = 27; i >= 0; i--) begin
         m = (m * m) >> 28;
         if (m >= (64'd1 << 29)) begin
            m      = m >> 1;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   localparam logic [31:0] LOG2_100 = 32'(log2_q28_f(32'd100));

   // Ceiling reciprocals 2^33/k for the series terms k = 1..16.
   localparam int EXP_TERMS = 16;
   localparam logic [63:0] TWO33 = 64'd1 << 33;
   localparam logic [33:0] EXP_RECIP [EXP_TERMS] = '{
      34'((TWO33 + 64'd0)  / 64'd1),  34'((TWO33 + 64'd1)  / 64'd2),
      34'((TWO33 + 64'd2)  / 64'd3),  34'((TWO33 + 64'd3)  / 64'd4),
      34'((TWO33 + 64'd4)  / 64'd5),  34'((TWO33 + 64'd5)  / 64'd6),
      34'((TWO33 + 64'd6)  / 64'd7),  34'((TWO33 + 64'd7)  / 64'd8),
      34'((TWO33 + 64'd8)  / 64'd9),  34'((TWO33 + 64'd9)  / 64'd10),
      34'((TWO33 + 64'd10) / 64'd11), 34'((TWO33 + 64'd11) / 64'd12),
      34'((TWO33 + 64'd12) / 64'd13), 34'((TWO33 + 64'd13) / 64'd14),
      34'((TWO33 + 64'd14) / 64'd15), 34'((TWO33 + 64'd15) / 64'd16)
   };

   // Pipeline depths.
   localparam int LN_SQ_STEPS    = 28;
   localparam int LN_LAT         = LN_SQ_STEPS + 3;
   localparam int LOGC_LAT       = 2;
   localparam int W_DIV_STAGES   = 3;
   localparam int POW_LAT        = 1 + W_DIV_STAGES + 2 * EXP_TERMS + 3;
   localparam int LVL_DIV_STAGES = 3;
   localparam int LVL_LAT        = 1 + LVL_DIV_STAGES;
   localparam int CORE_LAT       = LN_LAT + POW_LAT + LVL_LAT;
   localparam int LOG_DLY        = POW_LAT - LOGC_LAT;

   // Which curve applies to a temperature.
   typedef struct packed {
      logic le_knee;
      logic ge_knee;
      logic blue_off;
   } region_type;

endpackage

FILE: rtl/core/bbt_ln.sv
// Pipelined natural log of num/100 in Q28, floored at zero, one squaring step per stage.
// Depends on bbt_pkg.
module bbt_ln (
   input  logic                      clock,
   input  logic                      en,
   input  logic [bbt_pkg::KELVIN_W-1:0] num,
   output logic [bbt_pkg::LN_W-1:0]  ln
);
   import bbt_pkg::*;

   logic [3:0]  e_in;
   logic [43:0] sh;
   logic [28:0] m_ff   [LN_SQ_STEPS+1];
   logic [31:0] res_ff [LN_SQ_STEPS+1];
   logic [31:0] l_ff;
   logic [LN_W-1:0] ln_ff;
   logic [63:0] lp;

   // Normalize: find the leading one and scale the mantissa into [1,2).
   always_comb begin
      e_in = 4'd0;
      for (int b = 1; b < KELVIN_W; b++) begin
         if (num[b]) e_in = 4'(b);
      end
      sh = {num, 28'd0} >> e_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]   <= sh[28:0];
         res_ff[0] <= {e_in, 28'd0};
      end
   end

   // One fraction bit per stage by squaring the mantissa.
   for (genvar j = 1; j <= LN_SQ_STEPS; j++) begin : g_sq
      logic [57:0] sq;
      logic [29:0] t;
      logic [28:0] m_in;
      logic [31:0] res_in;
      always_comb begin
         sq     = m_ff[j-1] * m_ff[j-1];
         t      = sq[57:28];
         res_in = res_ff[j-1];
         if (t[29]) begin
            m_in                   = t[29:1];
            res_in[LN_SQ_STEPS-j]  = 1'b1;
         end else begin
            m_in = t[28:0];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[j]   <= m_in;
            res_ff[j] <= res_in;
         end
      end
   end

   // Remove log2(100), then convert to natural log.
   assign lp = l_ff * LN2_Q32;

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff  <= (res_ff[LN_SQ_STEPS] > LOG2_100) ? res_ff[LN_SQ_STEPS] - LOG2_100 : 32'd0;
         ln_ff <= lp[63:32];
      end
   end

   assign ln = ln_ff;

endmodule

FILE: rtl/core/bbt_logc.sv
// Log curve a*ln - b in units of 1e-9 of an output level, two stages.
// Depends on bbt_pkg.
module bbt_logc (
   input  logic                            clock,
   input  logic                            en,
   input  logic [bbt_pkg::LN_W-1:0]        ln,
   input  logic [bbt_pkg::COEF_W-1:0]      coef_a,
   input  logic [bbt_pkg::COEF_W-1:0]      coef_b,
   output logic signed [bbt_pkg::VAL_W-1:0] val
);
   import bbt_pkg::*;

   logic [45:0] ph_ff, pl_ff;
   logic [71:0] sum;
   logic signed [VAL_W-1:0] val_ff;

   // Split the coefficient so each product stays narrow.
   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff <= coef_a[39:20] * ln[31:6];
         pl_ff <= coef_a[19:0] * ln[31:6];
      end
   end

   assign sum = ({26'd0, ph_ff} << 20) + {26'd0, pl_ff};

   always_ff @(posedge clock) begin
      if (en) val_ff <= $signed(sum[69:22]) - $signed({8'd0, coef_b});
   end

   assign val = val_ff;

endmodule

FILE: rtl/core/bbt_powc.sv
// Power curve c*exp(-p*ln): multiply, reciprocal divide by 1e9, series exp, scale.
// Depends on bbt_pkg.
module bbt_powc (
   input  logic                            clock,
   input  logic                            en,
   input  logic [bbt_pkg::LN_W-1:0]        ln,
   input  logic [bbt_pkg::POWP_W-1:0]      coef_p,
   input  logic [bbt_pkg::COEF_W-1:0]      coef_c,
   output logic signed [bbt_pkg::VAL_W-1:0] val
);
   import bbt_pkg::*;

   logic [59:0]       x_ff;
   logic [60:0]       wq_p;
   logic [W_BITS-1:0] q0_ff, q1_ff, w_ff, w_in;
   logic [31:0]       xl1_ff, xl2_ff, r_w;
   logic [58:0]       pr_ff;

   logic [57:0]       ap_ff   [EXP_TERMS];
   logic [31:0]       apos_ff [EXP_TERMS];
   logic [31:0]       aneg_ff [EXP_TERMS];
   logic [W_BITS-1:0] aw_ff   [EXP_TERMS];
   logic [W_BITS-1:0] bt_ff   [EXP_TERMS];
   logic [31:0]       bpos_ff [EXP_TERMS];
   logic [31:0]       bneg_ff [EXP_TERMS];
   logic [W_BITS-1:0] bw_ff   [EXP_TERMS];

   logic [28:0] e_ff;
   logic [42:0] ch_ff, cl_ff;
   logic [63:0] csum;
   logic signed [VAL_W-1:0] val_ff;

   // Exponent scaled by 1e9.
   always_ff @(posedge clock) begin
      if (en) x_ff <= coef_p * ln;
   end

   // Division by 1e9: estimate from the top bits, which is low by at most two.
   assign wq_p = x_ff[57:26] * W_RECIP;

   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff  <= wq_p[60:32];
         xl1_ff <= x_ff[31:0];
         pr_ff  <= q0_ff * DIV_E9;
         q1_ff  <= q0_ff;
         xl2_ff <= xl1_ff;
         w_ff   <= w_in;
      end
   end

   // The remainder is below 3e9, so its low word settles the correction.
   always_comb begin
      r_w = xl2_ff - pr_ff[31:0];
      priority if (r_w >= DIV_2E9)        w_in = q1_ff + W_BITS'(2);
      else if (r_w >= {2'd0, DIV_E9})     w_in = q1_ff + W_BITS'(1);
      else                                w_in = q1_ff;
   end

   // Taylor series of exp(-w): term times w, then divide by k through a reciprocal.
   for (genvar k = 0; k < EXP_TERMS; k++) begin : g_exp
      logic [W_BITS-1:0] t_src, w_src;
      logic [31:0]       pos_src, neg_src;
      logic [63:0]       qp;
      logic [W_BITS-1:0] t_in;
      if (k == 0) begin : g_first
         assign t_src   = W_BITS'(1) << 28;
         assign w_src   = w_ff;
         assign pos_src = 32'd1 << 28;
         assign neg_src = 32'd0;
      end else begin : g_next
         assign t_src   = bt_ff[k-1];
         assign w_src   = bw_ff[k-1];
         assign pos_src = bpos_ff[k-1];
         assign neg_src = bneg_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ap_ff[k]   <= t_src * w_src;
            apos_ff[k] <= pos_src;
            aneg_ff[k] <= neg_src;
            aw_ff[k]   <= w_src;
         end
      end
      assign qp   = ap_ff[k][57:28] * EXP_RECIP[k];
      assign t_in = qp[61:33];
      always_ff @(posedge clock) begin
         if (en) begin
            bt_ff[k] <= t_in;
            bw_ff[k] <= aw_ff[k];
            // Odd powers subtract, even powers add.
            if (k % 2 == 0) begin
               bpos_ff[k] <= apos_ff[k];
               bneg_ff[k] <= aneg_ff[k] + {3'd0, t_in};
            end else begin
               bpos_ff[k] <= apos_ff[k] + {3'd0, t_in};
               bneg_ff[k] <= aneg_ff[k];
            end
         end
      end
   end

   // Combine the sums, saturating at zero, then scale by the coefficient.
   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= (bneg_ff[EXP_TERMS-1] > bpos_ff[EXP_TERMS-1]) ? 29'd0 :
                 29'(bpos_ff[EXP_TERMS-1] - bneg_ff[EXP_TERMS-1]);
         ch_ff <= coef_c[39:20] * e_ff[28:6];
         cl_ff <= coef_c[19:0] * e_ff[28:6];
      end
   end

   assign csum = ({21'd0, ch_ff} << 20) + {21'd0, cl_ff};

   always_ff @(posedge clock) begin
      if (en) val_ff <= $signed({6'd0, csum[63:22]});
   end

   assign val = val_ff;

endmodule

FILE: rtl/core/bbt_level.sv
// Saturate a curve value and round it onto the output level by reciprocal division.
// Depends on bbt_pkg.
module bbt_level (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [bbt_pkg::VAL_W-1:0] val,
   output logic [bbt_pkg::COLOR_BITS-1:0]  level
);
   import bbt_pkg::*;

   logic [39:0]             vu;
   logic [LVL_XW-1:0]       x;
   logic [LVL_XW-1:0]       x_ff;
   logic                    zero_ff [LVL_LAT];
   logic                    full_ff [LVL_LAT];
   logic [31+LVL_RW:0]      qp;
   logic [COLOR_BITS-1:0]   q0_ff, q1_ff, q_ff, q_in;
   logic [41:0]             xl1_ff, xl2_ff, r;
   logic [COLOR_BITS+39:0]  pr_ff;

   // v*M plus half of full scale; M = 2^COLOR_BITS - 1.
   assign vu = val[39:0];
   assign x  = ({vu, {COLOR_BITS{1'b0}}}) - LVL_XW'(vu) + LVL_XW'(HALF_U);

   // Saturation flags follow the quotient stages.
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (val <= 0);
         full_ff[0] <= (val >= FULL_S);
         for (int i = 1; i < LVL_LAT; i++) begin
            zero_ff[i] <= zero_ff[i-1];
            full_ff[i] <= full_ff[i-1];
         end
      end
   end

   // Quotient estimate from the top bits, low by at most two.
   assign qp = x_ff[LVL_XW-1 -: 32] * LVL_RECIP;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x;
         q0_ff  <= qp[32 +: COLOR_BITS];
         xl1_ff <= x_ff[41:0];
         pr_ff  <= q0_ff * FULL_U;
         q1_ff  <= q0_ff;
         xl2_ff <= xl1_ff;
         q_ff   <= q_in;
      end
   end

   // The remainder is below three times full scale; correct the estimate.
   always_comb begin
      r = xl2_ff - pr_ff[41:0];
      priority if (r >= {2'd0, FULL2_U})  q_in = q1_ff + COLOR_BITS'(2);
      else if (r >= {2'd0, FULL_U})       q_in = q1_ff + COLOR_BITS'(1);
      else                                q_in = q1_ff;
   end

   // Saturation overrides the quotient.
   always_comb begin
      priority if (zero_ff[LVL_LAT-1]) level = '0;
      else if (full_ff[LVL_LAT-1])     level = LEVEL_MAX;
      else                             level = q_ff;
   end

endmodule

FILE: rtl/core/blackbody_temperature_to_rgb.sv
// Blackbody color: kelvin in, RGB levels out, fully pipelined.
// Throughput: one beat per cycle; the whole pipeline advances when the output register
// is empty or taken, so the squaring chain of the log units sets the depth, not the rate.
// Reset: synchronous, active high; clears all valid bits, data registers are not reset.
// Depends on bbt_pkg, bbt_ln, bbt_logc, bbt_powc and bbt_level.
module blackbody_temperature_to_rgb (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bbt_pkg::REQ_W-1:0]   req_tdata,  // [15:0] temperature_kelvin
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [bbt_pkg::RSP_W-1:0]   rsp_tdata   // red_level, green_level, blue_level
);
   import bbt_pkg::*;

   logic                  en;
   logic [KELVIN_W-1:0]   kin;
   logic [KELVIN_W-1:0]   k_ff;
   logic                  vld_ff [CORE_LAT+1];
   region_type            reg_ff [CORE_LAT];
   region_type            reg_in;
   logic [KELVIN_W-1:0]   num_a, num_b;
   logic [LN_W-1:0]       ln_a, ln_b;
   logic signed [VAL_W-1:0] grn_log, blu_log, red_pow, grn_pow, grn_sel;
   logic signed [VAL_W-1:0] gd_ff [LOG_DLY];
   logic signed [VAL_W-1:0] bd_ff [LOG_DLY];
   logic [COLOR_BITS-1:0] red_lvl, grn_lvl, blu_lvl;
   logic [COLOR_BITS-1:0] red_ff, grn_ff, blu_ff;
   logic                  rsp_valid_ff;
   region_type            rg;

   // The pipeline moves whenever the output register can take a beat.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Clamp the input temperature.
   always_comb begin
      kin = req_tdata[KELVIN_W-1:0];
      if (kin < K_MIN) kin = K_MIN;
      if (kin > K_MAX) kin = K_MAX;
   end

   always_ff @(posedge clock) begin
      if (en) k_ff <= kin;
   end

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORE_LAT; i++) vld_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i <= CORE_LAT; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_valid_ff <= vld_ff[CORE_LAT];
      end
   end

   // Region flags ride along with the item.
   assign reg_in.le_knee  = (k_ff <= K_KNEE);
   assign reg_in.ge_knee  = (k_ff >= K_KNEE);
   assign reg_in.blue_off = (k_ff <= K_BLUE_OFF);

   always_ff @(posedge clock) begin
      if (en) begin
         reg_ff[0] <= reg_in;
         for (int i = 1; i < CORE_LAT; i++) reg_ff[i] <= reg_ff[i-1];
      end
   end

   // Log arguments: green and power curves share one, blue uses the other.
   assign num_a = reg_in.le_knee ? k_ff : k_ff - K_POW_OFS;
   assign num_b = k_ff - K_BLUE_OFS;

   bbt_ln u_ln_a (.clock(clock), .en(en), .num(num_a), .ln(ln_a));
   bbt_ln u_ln_b (.clock(clock), .en(en), .num(num_b), .ln(ln_b));

   bbt_logc u_grn_log (.clock(clock), .en(en), .ln(ln_a), .coef_a(GRN_A), .coef_b(GRN_B),
                       .val(grn_log));
   bbt_logc u_blu_log (.clock(clock), .en(en), .ln(ln_b), .coef_a(BLU_A), .coef_b(BLU_B),
                       .val(blu_log));
   bbt_powc u_red_pow (.clock(clock), .en(en), .ln(ln_a), .coef_p(RED_P), .coef_c(RED_C),
                       .val(red_pow));
   bbt_powc u_grn_pow (.clock(clock), .en(en), .ln(ln_a), .coef_p(GRN_P), .coef_c(GRN_C),
                       .val(grn_pow));

   // Delay the short log paths to line up with the power curves.
   always_ff @(posedge clock) begin
      if (en) begin
         gd_ff[0] <= grn_log;
         bd_ff[0] <= blu_log;
         for (int i = 1; i < LOG_DLY; i++) begin
            gd_ff[i] <= gd_ff[i-1];
            bd_ff[i] <= bd_ff[i-1];
         end
      end
   end

   assign grn_sel = reg_ff[LN_LAT+POW_LAT-1].le_knee ? gd_ff[LOG_DLY-1] : grn_pow;

   bbt_level u_red_lvl (.clock(clock), .en(en), .val(red_pow),          .level(red_lvl));
   bbt_level u_grn_lvl (.clock(clock), .en(en), .val(grn_sel),          .level(grn_lvl));
   bbt_level u_blu_lvl (.clock(clock), .en(en), .val(bd_ff[LOG_DLY-1]), .level(blu_lvl));

   // Output register with the fixed full-scale and off cases.
   assign rg = reg_ff[CORE_LAT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff <= rg.le_knee ? LEVEL_MAX : red_lvl;
         grn_ff <= grn_lvl;
         priority if (rg.ge_knee) blu_ff <= LEVEL_MAX;
         else if (rg.blue_off)    blu_ff <= '0;
         else                     blu_ff <= blu_lvl;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({blu_ff, grn_ff, red_ff});

   // Blue is only on its curve below the knee, where red is full scale.
   a_blue_curve_red_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && blu_ff != '0 && blu_ff != LEVEL_MAX |-> red_ff == LEVEL_MAX)
      else $error("blue on its curve while red is not full scale");

   // Red falls off only above the knee, where blue is full scale.
   a_red_falloff_blue_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && red_ff != LEVEL_MAX |-> blu_ff == LEVEL_MAX)
      else $error("red below full scale while blue is not full scale");

   // A held output beat stalls the whole pipeline, so the first and last valid bits hold.
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(vld_ff[CORE_LAT]) && $stable(vld_ff[0]))
      else $error("pipeline advanced during an output stall");

endmodule
